FILE: hw/rtl/cov_pkg.sv
`timescale 1ns / 1ps

package cov_pkg;

  localparam int CHAN_W      = 8;
  localparam int ARGB_W      = 32;
  localparam int COORD_W     = 12;
  localparam int ROW_W       = 6;
  localparam int POS_W       = 13;
  localparam int SIZE_W      = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int SUM_W       = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Pixel request after the rectangle test, waiting on the image store read.
  typedef struct packed {
    logic in_rect;
    rgb_t pix;
  } probe_t;

  // Exact floor(x / 255) for any x up to 255 * 255, the largest blend sum.
  function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] x);
    logic [SUM_W-1:0] s;
    s = x + {8'd0, x[SUM_W-1:8]} + 16'd1;
    return s[SUM_W-1:8];
  endfunction

endpackage

FILE: hw/rtl/cov_ram.sv
`timescale 1ns / 1ps

module cov_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/cov_locate.sv
`timescale 1ns / 1ps

module cov_locate #(
  parameter int CURSOR_MAX       = 64,
  parameter int FRAME_WIDTH_MAX  = 4096,
  parameter int FRAME_HEIGHT_MAX = 4096,
  localparam int CW = (CURSOR_MAX > 1) ? $clog2(CURSOR_MAX) : 1,
  localparam int AW = (CURSOR_MAX > 1) ? $clog2(CURSOR_MAX * CURSOR_MAX) : 1
) (
  input  logic [cov_pkg::COORD_W-1:0] pixel_x,
  input  logic [cov_pkg::COORD_W-1:0] pixel_y,
  input  logic [cov_pkg::POS_W-1:0]   cursor_left,
  input  logic [cov_pkg::POS_W-1:0]   cursor_top,
  input  logic [cov_pkg::SIZE_W-1:0]  cursor_width,
  input  logic [cov_pkg::SIZE_W-1:0]  cursor_height,
  output logic                        in_rect,
  output logic [AW-1:0]               addr
);

  import cov_pkg::*;

  logic [14:0] px_ext;
  logic [14:0] py_ext;
  logic [14:0] dx;
  logic [14:0] dy;
  logic [8:0]  w_eff;
  logic [8:0]  h_eff;
  logic        in_frame;

  always_comb begin
    px_ext = {3'b000, pixel_x};
    py_ext = {3'b000, pixel_y};
    // Offsets from the cursor corner; bit 14 is the sign.
    dx = px_ext - {{2{cursor_left[POS_W-1]}}, cursor_left};
    dy = py_ext - {{2{cursor_top[POS_W-1]}}, cursor_top};
    // Clamp oversized cursor dimensions to the store size.
    w_eff = ({2'b00, cursor_width} > 9'(CURSOR_MAX)) ? 9'(CURSOR_MAX) : {2'b00, cursor_width};
    h_eff = ({2'b00, cursor_height} > 9'(CURSOR_MAX)) ? 9'(CURSOR_MAX) : {2'b00, cursor_height};
    in_frame = (px_ext < 15'(FRAME_WIDTH_MAX)) && (py_ext < 15'(FRAME_HEIGHT_MAX));
    in_rect = in_frame
           && !dx[14] && (dx[13:0] < {5'd0, w_eff})
           && !dy[14] && (dy[13:0] < {5'd0, h_eff});
    addr = AW'(dy[CW-1:0]) * AW'(CURSOR_MAX) + AW'(dx[CW-1:0]);
  end

endmodule

FILE: hw/rtl/cov_blend.sv
`timescale 1ns / 1ps

module cov_blend (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         probe_valid,
  input  cov_pkg::probe_t              probe,
  input  logic [cov_pkg::ARGB_W-1:0]   word,
  output logic                         out_valid,
  output cov_pkg::rgb_t                out_pix,
  output logic                         out_hit
);

  import cov_pkg::*;

  logic              mix_valid;
  logic              mix_hit;
  logic [SUM_W-1:0]  sum_red;
  logic [SUM_W-1:0]  sum_green;
  logic [SUM_W-1:0]  sum_blue;
  logic [ARGB_W-1:0] cur_word;
  logic [CHAN_W-1:0] alpha;
  logic [CHAN_W-1:0] alpha_inv;

  // Outside the rectangle, a zero word makes the mix return the pixel itself
  // and keeps whatever the store returned out of the sums.
  always_comb begin
    cur_word  = probe.in_rect ? word : '0;
    alpha     = cur_word[31:24];
    alpha_inv = 8'd255 - alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      mix_valid <= probe_valid;
      out_valid <= mix_valid;
    end
    if (adv) begin
      mix_hit   <= (alpha != 8'd0);
      sum_red   <= SUM_W'(cur_word[23:16]) * SUM_W'(alpha)
                 + SUM_W'(probe.pix.red) * SUM_W'(alpha_inv);
      sum_green <= SUM_W'(cur_word[15:8]) * SUM_W'(alpha)
                 + SUM_W'(probe.pix.green) * SUM_W'(alpha_inv);
      sum_blue  <= SUM_W'(cur_word[7:0]) * SUM_W'(alpha)
                 + SUM_W'(probe.pix.blue) * SUM_W'(alpha_inv);
      out_hit         <= mix_hit;
      out_pix.red     <= div255(sum_red);
      out_pix.green   <= div255(sum_green);
      out_pix.blue    <= div255(sum_blue);
    end
  end

endmodule

FILE: hw/rtl/cursor_overlay_alpha_blend_core.sv
`timescale 1ns / 1ps
// Cursor overlay: blends a stored ARGB cursor image over a pixel stream.
// Throughput: one request per clock, load or pixel, fully pipelined, but a result
//   that m_axis has not taken stalls the whole pipeline.
// Pixel path: image store read, multiply, divide-by-255 output register.
// Reset: rst synchronous, active high; clears pipeline valids and cfg registers.
//   The image store is not cleared and must be loaded before use.

module cursor_overlay_alpha_blend_core #(
  parameter int CURSOR_MAX       = 64,
  parameter int FRAME_WIDTH_MAX  = 4096,
  parameter int FRAME_HEIGHT_MAX = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  // cursor_row[5:0], cursor_col[11:6], cursor_argb[43:12], pixel_x[55:44],
  // pixel_y[67:56], red_in[75:68], green_in[83:76], blue_in[91:84], zero pad
  input  logic [95:0]                        s_axis_tdata,
  input  logic [0:0]                         s_axis_tuser,  // command[0]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [23:0]                        m_axis_tdata,
  output logic [0:0]                         m_axis_tuser,  // cursor_hit[0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cov_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cov_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import cov_pkg::*;

  localparam int CW    = (CURSOR_MAX > 1) ? $clog2(CURSOR_MAX) : 1;
  localparam int AW    = (CURSOR_MAX > 1) ? $clog2(CURSOR_MAX * CURSOR_MAX) : 1;
  localparam int DEPTH = CURSOR_MAX * CURSOR_MAX;

  // Unpacked request fields.
  logic [ROW_W-1:0]   cursor_row;
  logic [ROW_W-1:0]   cursor_col;
  logic [ARGB_W-1:0]  cursor_argb;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  rgb_t               pix_in;
  logic               command;

  // Configuration registers.
  logic [POS_W-1:0]   cursor_left;
  logic [POS_W-1:0]   cursor_top;
  logic [SIZE_W-1:0]  cursor_width;
  logic [SIZE_W-1:0]  cursor_height;

  logic               adv;
  logic               accept;
  logic               in_rect;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  logic [8:0]         row_ext;
  logic [8:0]         col_ext;
  logic [ARGB_W-1:0]  word;

  logic               probe_valid;
  probe_t             probe;

  logic               out_valid;
  rgb_t               out_pix;
  logic               out_hit;

  assign cursor_row   = s_axis_tdata[5:0];
  assign cursor_col   = s_axis_tdata[11:6];
  assign cursor_argb  = s_axis_tdata[43:12];
  assign pixel_x      = s_axis_tdata[55:44];
  assign pixel_y      = s_axis_tdata[67:56];
  assign pix_in.red   = s_axis_tdata[75:68];
  assign pix_in.green = s_axis_tdata[83:76];
  assign pix_in.blue  = s_axis_tdata[91:84];
  assign command      = s_axis_tuser[0];

  // The whole pipeline moves together; it stalls only when the output
  // register holds a result that downstream has not taken.
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_left   <= '0;
      cursor_top    <= '0;
      cursor_width  <= '0;
      cursor_height <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LEFT:   cursor_left   <= cfg_data[POS_W-1:0];
        CFG_TOP:    cursor_top    <= cfg_data[POS_W-1:0];
        CFG_WIDTH:  cursor_width  <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT: cursor_height <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Load requests: drop writes that land outside the store.
  always_comb begin
    row_ext = {3'b000, cursor_row};
    col_ext = {3'b000, cursor_col};
    wr_en   = accept && (command == CMD_LOAD)
           && (row_ext < 9'(CURSOR_MAX)) && (col_ext < 9'(CURSOR_MAX));
    wr_addr = AW'(row_ext[CW-1:0]) * AW'(CURSOR_MAX) + AW'(col_ext[CW-1:0]);
  end

  // Rectangle test and image store address for pixel requests.
  cov_locate #(
    .CURSOR_MAX       (CURSOR_MAX),
    .FRAME_WIDTH_MAX  (FRAME_WIDTH_MAX),
    .FRAME_HEIGHT_MAX (FRAME_HEIGHT_MAX)
  ) u_locate (
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .cursor_left   (cursor_left),
    .cursor_top    (cursor_top),
    .cursor_width  (cursor_width),
    .cursor_height (cursor_height),
    .in_rect       (in_rect),
    .addr          (rd_addr)
  );

  // Cursor image store; the read data register lines up with the probe stage.
  cov_ram #(
    .WIDTH (ARGB_W),
    .DEPTH (DEPTH)
  ) u_image (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (cursor_argb),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (word)
  );

  // Probe stage: hold the pixel while the store read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_valid <= 1'b0;
    end else if (adv) begin
      probe_valid <= accept && (command == CMD_PIXEL);
    end
    if (adv) begin
      probe.in_rect <= in_rect;
      probe.pix     <= pix_in;
    end
  end

  // Multiply stage and divide-by-255 output register.
  cov_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .probe_valid (probe_valid),
    .probe       (probe),
    .word        (word),
    .out_valid   (out_valid),
    .out_pix     (out_pix),
    .out_hit     (out_hit)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_pix.blue, out_pix.green, out_pix.red};
  assign m_axis_tuser  = out_hit;

endmodule

FILE: tb/cursor_overlay_checker.sv
`timescale 1ns / 1ps

module cursor_overlay_checker #(
  parameter int CURSOR_MAX       = 64,
  parameter int FRAME_WIDTH_MAX  = 4096,
  parameter int FRAME_HEIGHT_MAX = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [95:0]                     s_axis_tdata,
  input  logic [0:0]                      s_axis_tuser,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [23:0]                     m_axis_tdata,
  input  logic [0:0]                      m_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [cov_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cov_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pending_count
);

  import cov_pkg::*;

  typedef struct packed {
    rgb_t pix;
    logic hit;
  } blend_t;

  logic [ARGB_W-1:0] image_words [0:CURSOR_MAX*CURSOR_MAX-1];
  int                cur_left;
  int                cur_top;
  int                cur_width;
  int                cur_height;
  int                fails;
  blend_t            blended_q [$];
  blend_t            got_res;
  blend_t            want_res;

  function automatic logic [CHAN_W-1:0] mix_chan(int c, int p, int a);
    int v;
    v = (c * a + p * (255 - a)) / 255;
    return v[CHAN_W-1:0];
  endfunction

  function automatic blend_t blend_pixel(int px, int py, rgb_t pix);
    blend_t            res;
    int                w;
    int                h;
    int                dx;
    int                dy;
    int                a;
    logic [ARGB_W-1:0] word;
    res.pix = pix;
    res.hit = 1'b0;
    w  = (cur_width > CURSOR_MAX) ? CURSOR_MAX : cur_width;
    h  = (cur_height > CURSOR_MAX) ? CURSOR_MAX : cur_height;
    dx = px - cur_left;
    dy = py - cur_top;
    if (px < FRAME_WIDTH_MAX && py < FRAME_HEIGHT_MAX &&
        dx >= 0 && dx < w && dy >= 0 && dy < h) begin
      word = image_words[dy * CURSOR_MAX + dx];
      a    = int'(word[31:24]);
      // transparent entries leave the pixel alone
      if (a != 0) begin
        res.pix.red   = mix_chan(int'(word[23:16]), int'(pix.red), a);
        res.pix.green = mix_chan(int'(word[15:8]), int'(pix.green), a);
        res.pix.blue  = mix_chan(int'(word[7:0]), int'(pix.blue), a);
        res.hit       = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      blended_q.delete();
      cur_left   = 0;
      cur_top    = 0;
      cur_width  = 0;
      cur_height = 0;
      fails      = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEFT:   cur_left   = int'($signed(cfg_data));
          CFG_TOP:    cur_top    = int'($signed(cfg_data));
          CFG_WIDTH:  cur_width  = int'(cfg_data[SIZE_W-1:0]);
          CFG_HEIGHT: cur_height = int'(cfg_data[SIZE_W-1:0]);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == CMD_LOAD) begin
          image_words[int'(s_axis_tdata[5:0]) * CURSOR_MAX + int'(s_axis_tdata[11:6])] =
            s_axis_tdata[43:12];
        end else begin
          blended_q = {blended_q,
                       blend_pixel(int'(s_axis_tdata[55:44]), int'(s_axis_tdata[67:56]),
                                   {s_axis_tdata[75:68], s_axis_tdata[83:76],
                                    s_axis_tdata[91:84]})};
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                   m_axis_tuser[0]};
        if (blended_q.size() == 0) begin
          $error("result with no pixel request outstanding: %h", got_res);
          fails++;
        end else begin
          want_res = blended_q.pop_front();
          if (got_res.pix.red !== want_res.pix.red) begin
            $error("red_out: expected %0d, got %0d", want_res.pix.red, got_res.pix.red);
            fails++;
          end
          if (got_res.pix.green !== want_res.pix.green) begin
            $error("green_out: expected %0d, got %0d", want_res.pix.green,
                   got_res.pix.green);
            fails++;
          end
          if (got_res.pix.blue !== want_res.pix.blue) begin
            $error("blue_out: expected %0d, got %0d", want_res.pix.blue, got_res.pix.blue);
            fails++;
          end
          if (got_res.hit !== want_res.hit) begin
            $error("cursor_hit: expected %0d, got %0d", want_res.hit, got_res.hit);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    pending_count <= blended_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import cov_pkg::*;

  localparam int SIDE         = 64;    // cursor store is SIDE x SIDE words
  localparam int DRAIN_CYCLES = 8;     // pipeline is three deep, leave margin
  localparam int HOLD_CYCLES  = 200;   // one long back-pressure stretch
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 75;
  localparam int END_LIMIT    = 2000;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic [95:0] s_tdata    = '0;
  logic [0:0]  s_tuser    = '0;
  logic        s_tvalid   = 1'b0;
  logic        s_tready;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tvalid;
  logic        m_tready   = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int   fails;
  int   pending;

  // Shadow of the cursor placement and of which store entries hold data, so
  // that no pixel request ever reads an entry that was never loaded.
  int   sh_left;
  int   sh_top;
  int   sh_w;
  int   sh_h;
  bit   written [0:SIDE*SIDE-1];

  logic hold_armed = 1'b0;
  bit   hold_done;
  logic calm       = 1'b0;

  cursor_overlay_alpha_blend_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  cursor_overlay_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fails),
    .pending_count (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(5_000_000);
    $display("cursor_overlay_alpha_blend_core test failed");
    $finish;
  end

  // Result side: ready in random runs broken by random stalls, one long hold-off
  // once armed so the pipeline backs up into s_axis, no stalls at the end.
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Pack one request, first field in the low bits.
  function automatic logic [95:0] item_word(logic [5:0] row, logic [5:0] col,
                                            logic [31:0] argb, logic [11:0] px,
                                            logic [11:0] py, logic [7:0] r,
                                            logic [7:0] g, logic [7:0] b);
    return {4'd0, b, g, r, py, px, argb, col, row};
  endfunction

  // Mostly random color channel, with the extremes showing up often.
  function automatic logic [7:0] channel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Cursor word with alpha biased toward transparent, opaque and near-extreme.
  function automatic logic [31:0] cursor_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 6))
      0:       w[31:24] = 8'h00;
      1:       w[31:24] = 8'hff;
      2:       w[31:24] = 8'h01;
      3:       w[31:24] = 8'hfe;
      default: ;
    endcase
    return w;
  endfunction

  // Offer one request, maybe after an idle burst, and hold it until accepted.
  task automatic offer(logic cmd, logic [95:0] word);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tuser  <= cmd;
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Load request; pixel fields carry noise the block must ignore.
  task automatic send_load(int row, int col, logic [31:0] argb);
    offer(CMD_LOAD, item_word(6'(row), 6'(col), argb, 12'($urandom), 12'($urandom),
                              8'($urandom), 8'($urandom), 8'($urandom)));
    written[row * SIDE + col] = 1'b1;
  endtask

  // Pixel request; load the entry it hits first if that entry is still empty.
  task automatic send_pixel(int px, int py, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int dx;
    int dy;
    dx = px - sh_left;
    dy = py - sh_top;
    if (dx >= 0 && dx < sh_w && dy >= 0 && dy < sh_h && !written[dy * SIDE + dx])
      send_load(dy, dx, cursor_word());
    offer(CMD_PIXEL, item_word(6'($urandom), 6'($urandom), $urandom, 12'(px), 12'(py),
                               r, g, b));
  endtask

  task automatic cfg_write(cfg_reg_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drain the pipeline, then move the cursor. Loads give no result, so wait
  // out the pipeline depth after the last result as well.
  task automatic set_cursor(int left, int top, int width, int height);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(CFG_LEFT, left);
    cfg_write(CFG_TOP, top);
    cfg_write(CFG_WIDTH, width);
    cfg_write(CFG_HEIGHT, height);
    cfg_valid <= 1'b0;
    sh_left = left;
    sh_top  = top;
    sh_w    = (width > SIDE) ? SIDE : width;
    sh_h    = (height > SIDE) ? SIDE : height;
  endtask

  initial begin
    int px;
    int py;
    int row;
    int col;
    int n;
    sh_left = 0;
    sh_top  = 0;
    sh_w    = 0;
    sh_h    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset placement has zero size: pixels at both frame corners pass through.
    send_pixel(0, 0, 8'h00, 8'h00, 8'h00);
    send_pixel(4095, 4095, 8'hff, 8'hff, 8'hff);

    // Oversized cursor clamps to the store side.
    set_cursor(0, 0, 127, 100);
    send_load(0, 0, 32'hff123456);     // opaque
    send_load(0, 1, 32'h00abcdef);     // transparent
    send_load(63, 63, 32'h01ffffff);   // barely visible
    send_load(5, 63, 32'h80ff0000);
    send_pixel(0, 0, 8'h11, 8'h22, 8'h33);
    send_pixel(1, 0, 8'hff, 8'h80, 8'h00);
    send_pixel(63, 63, 8'h00, 8'h00, 8'h00);
    send_pixel(63, 5, 8'hff, 8'hff, 8'hff);
    send_pixel(64, 63, 8'h5a, 8'ha5, 8'h3c);   // one past the clamped width
    send_pixel(0, 64, 8'h5a, 8'ha5, 8'h3c);    // one past the clamped height

    // Cursor at the far bottom-right corner: only the corner pixel blends.
    set_cursor(4095, 4095, 64, 64);
    send_pixel(4095, 4095, 8'h40, 8'h80, 8'hc0);
    send_pixel(4094, 4095, 8'h40, 8'h80, 8'hc0);

    // Cursor far off the top-left: nothing blends.
    set_cursor(-4096, -4096, 64, 64);
    send_pixel(0, 0, 8'h12, 8'h34, 8'h56);
    send_pixel(63, 63, 8'h12, 8'h34, 8'h56);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: set_cursor(0, 0, 64, 64);
        1: set_cursor(int'($urandom_range(0, 4159)) - 64, int'($urandom_range(0, 4159)) - 64,
                      $urandom_range(1, 64), $urandom_range(1, 64));
        2: set_cursor(4095, 4095, 127, 127);
        3: set_cursor(-4096, -4096, 64, 64);
        4: set_cursor($urandom_range(0, 200), $urandom_range(0, 200), 0, 64);
        5: set_cursor(-20, -20, 127, 65);
        6: set_cursor($urandom_range(0, 4095), $urandom_range(0, 4095), 1, 1);
        default: set_cursor(int'($urandom_range(0, 8191)) - 4096,
                            int'($urandom_range(0, 8191)) - 4096,
                            $urandom_range(0, 127), $urandom_range(0, 127));
      endcase
      // Back up the pipeline once, early on; run the final phase without gaps.
      if (ph == 1)
        hold_armed <= 1'b1;
      if (ph == N_PHASES - 1)
        calm <= 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          // Loads land mostly inside the visible part of the image.
          if (sh_w > 0 && sh_h > 0 && $urandom_range(0, 9) < 7) begin
            row = $urandom_range(0, sh_h - 1);
            col = $urandom_range(0, sh_w - 1);
          end else begin
            row = $urandom_range(0, SIDE - 1);
            col = $urandom_range(0, SIDE - 1);
          end
          send_load(row, col, cursor_word());
        end else begin
          // Aim most pixels at the cursor, some just past an edge.
          if (sh_w > 0 && sh_h > 0 && $urandom_range(0, 9) < 7) begin
            px = sh_left + int'($urandom_range(0, sh_w - 1));
            py = sh_top + int'($urandom_range(0, sh_h - 1));
            if ($urandom_range(0, 7) == 0)
              px = $urandom_range(0, 1) ? sh_left + sh_w : sh_left - 1;
            if ($urandom_range(0, 7) == 0)
              py = $urandom_range(0, 1) ? sh_top + sh_h : sh_top - 1;
          end else begin
            px = $urandom_range(0, 4095);
            py = $urandom_range(0, 4095);
          end
          if (px < 0 || px > 4095)
            px = $urandom_range(0, 4095);
          if (py < 0 || py > 4095)
            py = $urandom_range(0, 4095);
          send_pixel(px, py, channel(), channel(), channel());
        end
      end
    end

    // Drop valid and let every outstanding pixel come back.
    s_tvalid <= 1'b0;
    @(posedge clk);
    n = 0;
    while (pending != 0 && n < END_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("cursor_overlay_alpha_blend_core test passed");
    end else begin
      $display("cursor_overlay_alpha_blend_core test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/cov_pkg.sv
hw/rtl/cov_ram.sv
hw/rtl/cov_locate.sv
hw/rtl/cov_blend.sv
hw/rtl/cursor_overlay_alpha_blend_core.sv
tb/cursor_overlay_checker.sv
tb/tb_top.sv
